[hdl/sfk_pkg.sv]
// Shared types and constants for the synchronized timestamp keeper.
// Used by sfk_frame, sfk_clock and sync_frame_timestamp_keeper; depends on nothing.
`default_nettype none

package sfk_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'hAF;

  localparam int MICROS_W = 20;
  localparam int ADJ_W    = 21;
  localparam int SUB_SHIFT = 5;
  localparam int SUB_W    = MICROS_W - SUB_SHIFT;
  localparam int OUT_SEC_W = 40;

  localparam logic [MICROS_W-1:0] US_LAST = MICROS_W'(1000000 - 1);
  localparam logic signed [ADJ_W-1:0] ADJ_RESET = ADJ_W'(10 - 572);

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [31:0] set_seconds;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SEC_W-1:0] seconds;
    logic [SUB_W-1:0]     sub_ticks;
    logic                 from_sync;
  } out_item_t;

  typedef struct packed {
    logic        at_last;
    logic [31:0] sync_secs;
  } frame_status_t;

endpackage

`default_nettype wire

[hdl/sync_frame_timestamp_keeper.sv]
// Top level of the synchronized timestamp keeper: input register, execute step, result register.
// Depends on sfk_pkg, sfk_frame and sfk_clock.
//
// Usage:
//   in_*  : one command word per handshake (tick, received byte, read, write seconds).
//   out_* : one result word for each read and for each completed sync frame.
//   cfg_* : writes the signed sync adjust in microseconds; always ready.
// A word accepted on the input is held in the input register until it can execute,
// and its result is written to the output register as it executes.
// Throughput is one word per cycle while no result is stalled; ticks, writes and bytes
// that end no frame never wait on the output. When the receiver stalls with a result pending,
// a word that would make another result waits in the input register and in_ready falls.
// Reset clears the clock to zero, restarts frame matching, empties both registers and
// sets the adjust to -562 microseconds.
`default_nettype none

module sync_frame_timestamp_keeper
  import sfk_pkg::*;
#(
  parameter int SECONDS_WIDTH = 40
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_item_t                    out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic signed [ADJ_W-1:0] cfg_data
);

  logic signed [ADJ_W-1:0] adjust_r;
  in_item_t                s1_r;
  logic                    s1_valid_r;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  frame_status_t            frame_st;
  logic                     has_result, go;
  logic                     is_tick, is_byte, is_read, is_write, sync_now;
  logic [SECONDS_WIDTH-1:0] seconds_nxt;
  logic [MICROS_W-1:0]      micros_nxt;
  logic [OUT_SEC_W-1:0]     seconds_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adjust_r <= ADJ_RESET;
    end else if (cfg_valid) begin
      adjust_r <= cfg_data;
    end
  end

  assign is_tick  = (s1_r.command == CMD_TICK);
  assign is_byte  = (s1_r.command == CMD_BYTE);
  assign is_read  = (s1_r.command == CMD_READ);
  assign is_write = (s1_r.command == CMD_WRITE);

  assign has_result = is_read || (is_byte && frame_st.at_last);
  assign go         = s1_valid_r && (!has_result || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || go;
  assign sync_now   = go && is_byte && frame_st.at_last;

  sfk_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (go && is_byte),
    .rx_byte (s1_r.rx_byte),
    .status  (frame_st)
  );

  sfk_clock #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_clock (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (go && is_tick),
    .write_en    (go && is_write),
    .sync_en     (sync_now),
    .set_seconds (s1_r.set_seconds),
    .sync_secs   (frame_st.sync_secs),
    .adjust      (adjust_r),
    .seconds_nxt (seconds_nxt),
    .micros_nxt  (micros_nxt)
  );

  generate
    if (SECONDS_WIDTH >= OUT_SEC_W) begin : g_sec_trunc
      assign seconds_out = seconds_nxt[OUT_SEC_W-1:0];
    end else begin : g_sec_ext
      assign seconds_out = OUT_SEC_W'(seconds_nxt);
    end
  endgenerate

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (go && has_result) begin
      // Read results see an unchanged clock, so the next value serves both cases.
      out_nxt.seconds   = seconds_out;
      out_nxt.sub_ticks = micros_nxt[MICROS_W-1:SUB_SHIFT];
      out_nxt.from_sync = is_byte;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[hdl/sfk_frame.sv]
// Sync frame matcher: header bytes 0xAA 0xAF, then four little-endian seconds bytes.
// Depends on sfk_pkg.
`default_nettype none

module sfk_frame
  import sfk_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_en,
  input  wire logic [7:0]    rx_byte,
  output frame_status_t      status
);

  localparam logic [2:0] POS_HDR0 = 3'd0;
  localparam logic [2:0] POS_HDR1 = 3'd1;
  localparam logic [2:0] POS_P0   = 3'd2;
  localparam logic [2:0] POS_P1   = 3'd3;
  localparam logic [2:0] POS_P2   = 3'd4;
  localparam logic [2:0] POS_P3   = 3'd5;

  logic [2:0]  frame_pos_r, frame_pos_nxt;
  logic [23:0] payload_low_r, payload_low_nxt;

  always_comb begin
    frame_pos_nxt   = frame_pos_r;
    payload_low_nxt = payload_low_r;
    if (byte_en) begin
      case (frame_pos_r)
        POS_HDR0: frame_pos_nxt = (rx_byte == HDR0) ? POS_HDR1 : POS_HDR0;
        POS_HDR1: frame_pos_nxt = (rx_byte == HDR1) ? POS_P0 : POS_HDR0;
        POS_P0: begin
          payload_low_nxt[7:0] = rx_byte;
          frame_pos_nxt        = POS_P1;
        end
        POS_P1: begin
          payload_low_nxt[15:8] = rx_byte;
          frame_pos_nxt         = POS_P2;
        end
        POS_P2: begin
          payload_low_nxt[23:16] = rx_byte;
          frame_pos_nxt          = POS_P3;
        end
        default: frame_pos_nxt = POS_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r   <= POS_HDR0;
      payload_low_r <= '0;
    end else begin
      frame_pos_r   <= frame_pos_nxt;
      payload_low_r <= payload_low_nxt;
    end
  end

  assign status.at_last   = (frame_pos_r == POS_P3);
  assign status.sync_secs = {rx_byte, payload_low_r};

endmodule

`default_nettype wire

[hdl/sfk_clock.sv]
// Seconds and microseconds counters with tick, write and sync load.
// Depends on sfk_pkg.
`default_nettype none

module sfk_clock
  import sfk_pkg::*;
#(
  parameter int SECONDS_WIDTH = 40
)
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          tick_en,
  input  wire logic                          write_en,
  input  wire logic                          sync_en,
  input  wire logic [31:0]                   set_seconds,
  input  wire logic [31:0]                   sync_secs,
  input  wire logic signed [ADJ_W-1:0]       adjust,
  output logic      [SECONDS_WIDTH-1:0]      seconds_nxt,
  output logic      [MICROS_W-1:0]           micros_nxt
);

  logic [SECONDS_WIDTH-1:0] seconds_r;
  logic [MICROS_W-1:0]      micros_r;

  // The adjust range allows a floor quotient of -2..1 seconds; delta is that plus one.
  logic signed [22:0] adj_ext;
  logic signed [22:0] adj_norm;
  logic signed [2:0]  delta;

  always_comb begin
    adj_ext = 23'(adjust);
    if (adj_ext < -23'sd1000000) begin
      adj_norm = adj_ext + 23'sd2000000;
      delta    = -3'sd1;
    end else if (adj_ext < 23'sd0) begin
      adj_norm = adj_ext + 23'sd1000000;
      delta    = 3'sd0;
    end else if (adj_ext >= 23'sd1000000) begin
      adj_norm = adj_ext - 23'sd1000000;
      delta    = 3'sd2;
    end else begin
      adj_norm = adj_ext;
      delta    = 3'sd1;
    end
  end

  always_comb begin
    seconds_nxt = seconds_r;
    micros_nxt  = micros_r;
    if (tick_en) begin
      if (micros_r == US_LAST) begin
        micros_nxt  = '0;
        seconds_nxt = seconds_r + SECONDS_WIDTH'(1);
      end else begin
        micros_nxt = micros_r + MICROS_W'(1);
      end
    end else if (write_en) begin
      seconds_nxt = SECONDS_WIDTH'(set_seconds);
      micros_nxt  = '0;
    end else if (sync_en) begin
      seconds_nxt = SECONDS_WIDTH'(sync_secs) + {{(SECONDS_WIDTH-3){delta[2]}}, delta};
      micros_nxt  = adj_norm[MICROS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
      micros_r  <= '0;
    end else begin
      seconds_r <= seconds_nxt;
      micros_r  <= micros_nxt;
    end
  end

endmodule

`default_nettype wire

[sim/sync_frame_timestamp_keeper_tb.sv]
// Self-checking testbench for sync_frame_timestamp_keeper: directed and random command words.
// Depends on sfk_pkg and the sync_frame_timestamp_keeper RTL; needs no other files.
// A timestamp tracker predicts each read and sync result; a checker compares them in order.

module sync_frame_timestamp_keeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfk_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int SECONDS_W    = 40;
  localparam int US_PER_SEC   = 1000000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_WORDS  = 175;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic signed [ADJ_W-1:0] cfg_data;

  // Tracked copy of the block's clock, frame matcher and adjust register.
  logic signed [ADJ_W-1:0] adjust_us = ADJ_RESET;
  logic [2:0]              frame_pos = '0;
  logic [23:0]             payload_lo = '0;
  logic [SECONDS_W-1:0]    clock_sec = '0;
  logic [MICROS_W-1:0]     clock_us = '0;

  out_item_t stamps_due[$];
  out_item_t oldest_stamp;

  int  mismatches = 0;
  int  words_sent = 0;
  int  reads_checked = 0;
  int  syncs_checked = 0;
  int  adjust_settings = 1;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  idle_cycles = 0;

  int  hold_requests = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  stall_mode = 0;
  int  stall_left = 0;

  sync_frame_timestamp_keeper #(
    .SECONDS_WIDTH(SECONDS_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Timestamp tracking
  // ---------------------------------------------------------------------------

  function automatic void push_stamp(input logic flag);
    out_item_t stamp;
    stamp.seconds   = clock_sec[OUT_SEC_W-1:0];
    stamp.sub_ticks = clock_us[MICROS_W-1:SUB_SHIFT];
    stamp.from_sync = flag;
    stamps_due.push_back(stamp);
  endfunction

  // The adjust may exceed one second either way, so the seconds borrow or carry.
  function automatic void apply_sync_frame(input logic [31:0] secs);
    logic [SECONDS_W-1:0] s;
    int a;
    s = SECONDS_W'(secs) + SECONDS_W'(1);
    a = adjust_us;
    while (a < 0) begin
      a += US_PER_SEC;
      s -= SECONDS_W'(1);
    end
    while (a >= US_PER_SEC) begin
      a -= US_PER_SEC;
      s += SECONDS_W'(1);
    end
    clock_sec = s;
    clock_us  = MICROS_W'(a);
  endfunction

  function automatic void track_timestamp(input in_item_t w);
    case (w.command)
      CMD_TICK: begin
        if (clock_us == US_LAST) begin
          clock_us  = '0;
          clock_sec = clock_sec + SECONDS_W'(1);
        end else begin
          clock_us = clock_us + MICROS_W'(1);
        end
      end
      CMD_BYTE: begin
        // Positions 0 and 1 match the header, 2 to 5 collect the payload.
        case (frame_pos)
          3'd0: frame_pos = (w.rx_byte == HDR0) ? 3'd1 : 3'd0;
          3'd1: frame_pos = (w.rx_byte == HDR1) ? 3'd2 : 3'd0;
          3'd2, 3'd3, 3'd4: begin
            payload_lo[8*(frame_pos-3'd2) +: 8] = w.rx_byte;
            frame_pos = frame_pos + 3'd1;
          end
          3'd5: begin
            apply_sync_frame({w.rx_byte, payload_lo});
            frame_pos = 3'd0;
            push_stamp(1'b1);
          end
          default: frame_pos = 3'd0;
        endcase
      end
      CMD_READ: push_stamp(1'b0);
      default: begin
        clock_sec = SECONDS_W'(w.set_seconds);
        clock_us  = '0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (stamps_due.size() == 0) begin
        $display("%0t ns: result word with nothing expected, expected none, got %p",
                 $time, out_data);
        mismatches++;
      end else begin
        oldest_stamp = stamps_due.pop_front();
        check_field("seconds", 64'(oldest_stamp.seconds), 64'(out_data.seconds));
        check_field("sub_ticks", 64'(oldest_stamp.sub_ticks), 64'(out_data.sub_ticks));
        check_field("from_sync", 64'(oldest_stamp.from_sync), 64'(out_data.from_sync));
        if (oldest_stamp.from_sync) syncs_checked++;
        else reads_checked++;
      end
    end
  end

  // Receiver: a changing stall pattern, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, stamps_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] b, input logic [31:0] s);
    in_item_t w;
    w.command     = cmd;
    w.rx_byte     = b;
    w.set_seconds = s;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    track_timestamp(w);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_cmd(CMD_BYTE, b, $urandom);
  endtask

  // Ticks and reads may fall between the bytes of a frame without breaking it.
  task automatic send_frame(input logic [31:0] secs, input bit interleave);
    logic [7:0] frame_bytes[6];
    frame_bytes = '{HDR0, HDR1, secs[7:0], secs[15:8], secs[23:16], secs[31:24]};
    foreach (frame_bytes[i]) begin
      if (interleave && $urandom_range(0, 3) == 0) begin
        send_cmd(($urandom_range(0, 2) == 0) ? CMD_READ : CMD_TICK, 8'($urandom), $urandom);
      end
      send_byte(frame_bytes[i]);
    end
  endtask

  // Lets every expected result arrive and the pipeline settle.
  task automatic wait_for_drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (stamps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_adjust(input int value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ADJ_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    adjust_us = ADJ_W'(value);
    adjust_settings++;
  endtask

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_state();
    send_cmd(CMD_READ, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK, 8'hAA, 32'h0);
    send_cmd(CMD_TICK, 8'h55, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 8'h00, 32'h0);
    send_cmd(CMD_WRITE, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 8'hAA, 32'h5555_AAAA);
  endtask

  task automatic test_frame_matching();
    send_frame(32'h0000_0000, 1'b0);
    send_cmd(CMD_READ, 8'h00, 32'h0);
    // A wrong second header byte restarts matching, and is not retried as a first byte.
    send_byte(HDR0);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(8'h00);
    // Writes and reads in the middle of a frame leave the matcher where it was.
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_cmd(CMD_WRITE, 8'h00, 32'h1234_5678);
    send_cmd(CMD_READ, 8'h00, 32'h0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_cmd(CMD_READ, 8'h00, 32'h0);
  endtask

  // An adjust just under minus one second turns a zero payload into the last
  // representable second; the next tick past the end of that second wraps to zero.
  task automatic test_seconds_wrap();
    write_adjust(-1000001);
    send_frame(32'h0000_0000, 1'b0);
    send_cmd(CMD_READ, 8'h00, 32'h0);
    send_cmd(CMD_TICK, 8'h00, 32'h0);
    send_cmd(CMD_READ, 8'h00, 32'h0);
  endtask

  task automatic test_backpressure();
    int k;
    gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (k = 0; k < 60; k++) begin
      send_cmd((k % 3 == 0) ? CMD_READ : CMD_TICK, 8'($urandom), $urandom);
    end
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int adjust, input int n_words, input bit gaps);
    int first;
    int pick;
    logic [7:0] b;
    write_adjust(adjust);
    gaps_on = gaps;
    first = words_sent;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_frame(pick_payload(), $urandom_range(0, 1));
      end else if (pick < 45) begin
        send_byte(HDR0);
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom);
          if (b == HDR1) b = HDR0;
          send_byte(b);
        end else begin
          // Cut-short payload: later bytes finish this frame instead.
          send_byte(HDR1);
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 30)) send_cmd(CMD_TICK, 8'($urandom), $urandom);
      end else if (pick < 82) begin
        send_cmd(CMD_READ, 8'($urandom), $urandom);
      end else if (pick < 88) begin
        send_cmd(CMD_WRITE, 8'($urandom), pick_payload());
      end else begin
        send_byte(8'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_frame_matching();
    test_seconds_wrap();
    test_backpressure();
    test_random_traffic(-1048576, PHASE_WORDS, 1'b1);
    test_random_traffic(1048575, PHASE_WORDS, 1'b0);
    test_random_traffic(0, PHASE_WORDS, 1'b1);
    test_random_traffic(-999999, PHASE_WORDS, 1'b1);
    test_random_traffic(-$urandom_range(0, 999999), PHASE_WORDS, 1'b0);
    test_random_traffic(int'($urandom_range(0, 2097151)) - 1048576, PHASE_WORDS, 1'b1);
    wait_for_drain();

    $display("Run covered %0d command words under %0d adjust settings;", words_sent,
             adjust_settings);
    $display("checked %0d read results and %0d sync frame results.", reads_checked,
             syncs_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sfk_pkg.sv
hdl/sfk_frame.sv
hdl/sfk_clock.sv
hdl/sync_frame_timestamp_keeper.sv
sim/sync_frame_timestamp_keeper_tb.sv
